// ----- hdl/rrts_pkg.sv -----
package rrts_pkg;

    localparam int NumTasks = 16;
    localparam int NumSems  = 8;
    localparam int TidW     = $clog2(NumTasks);
    localparam int SemW     = 3;
    localparam int CntW     = TidW + 1;
    localparam int SliceW   = 3;
    localparam int TickW    = 8;
    localparam int SleepW   = 20;
    localparam int SemCntW  = 8;
    localparam int InW      = 32;
    localparam int OutW     = 16;

    typedef logic [TidW-1:0] tid_t;

    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_SPAWN  = 3'd1,
        OP_WAIT   = 3'd2,
        OP_SIGNAL = 3'd3,
        OP_SLEEP  = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_NO_ID   = 2'd1,
        STAT_NOBLOCK = 2'd2
    } stat_t;

    localparam logic [0:0] REG_SLICE = 1'b0;
    localparam logic [0:0] REG_TICK  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SLICE,
        S_EXEC,
        S_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture input beat
        logic scan_clr; // reset walk index
        logic scan_step;// process one sleeper or one spawn candidate
        logic slice;    // run the time-slice rule
        logic exec;     // run the non-tick event
        logic emit;     // load the result register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_tick;
        logic scan_done;
    } sts_t;

endpackage

// ----- hdl/rrts_ctrl.sv -----
module rrts_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_fire,
    input  logic          out_free,
    input  rrts_pkg::sts_t sts,
    output rrts_pkg::cmd_t cmd,
    output logic          busy
);
    import rrts_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else          state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_fire) state_next = S_SCAN;
            S_SCAN:  if (sts.scan_done) state_next = sts.is_tick ? S_SLICE : S_EXEC;
            S_SLICE: state_next = S_DONE;
            S_EXEC:  state_next = S_DONE;
            S_DONE:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        cmd.load = (state_reg == S_IDLE) && in_fire;
        case (state_reg)
            S_SCAN:  cmd.scan_step = !sts.scan_done;
            S_SLICE: cmd.slice = 1'b1;
            S_EXEC:  cmd.exec = 1'b1;
            S_DONE:  cmd.emit = out_free;
            default: cmd.scan_clr = 1'b1;
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ----- hdl/rrts_dp.sv -----
module rrts_dp (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  rrts_pkg::cmd_t              cmd,
    output rrts_pkg::sts_t              sts,
    input  logic [rrts_pkg::InW-1:0]    in_data,
    input  logic                        cfg_we,
    input  logic                        cfg_idx,
    input  logic [rrts_pkg::TickW-1:0]  cfg_data,
    output logic [rrts_pkg::OutW-1:0]   res_data,
    output logic                        res_load
);
    import rrts_pkg::*;

    logic [SliceW-1:0]  slice_ticks_reg;
    logic [TickW-1:0]   tick_ms_reg;
    logic [2:0]         op_reg;
    logic [SemW-1:0]    sem_reg;
    logic [SleepW-1:0]  ms_reg;

    logic [NumTasks-1:0] used_reg;
    tid_t               fifo_reg [NumTasks];
    tid_t               head_reg, tail_reg;
    logic [CntW-1:0]    count_reg;
    tid_t               cur_reg, before_reg;
    logic [SliceW-1:0]  slice_reg [NumTasks];
    logic [SemCntW-1:0] semc_reg [NumSems];
    tid_t               wtop_reg [NumSems];
    tid_t               link_reg [NumTasks];
    logic [SleepW-1:0]  sleft_reg [NumTasks];
    tid_t               sord_reg [NumTasks];
    logic [CntW-1:0]    slen_reg;
    logic [CntW-1:0]    rd_reg, wr_reg;
    tid_t               newid_reg;
    logic [1:0]         stat_reg;

    tid_t               st;
    logic               found;

    always_comb begin
        st = sord_reg[rd_reg[TidW-1:0]];
        found = (rd_reg != '0) && (rd_reg < CntW'(NumTasks)) && !used_reg[rd_reg[TidW-1:0]];
        sts.is_tick = (op_reg == OP_TICK);
        if (op_reg == OP_TICK)       sts.scan_done = (rd_reg >= slen_reg);
        else if (op_reg == OP_SPAWN) sts.scan_done = found || (rd_reg == CntW'(NumTasks));
        else                         sts.scan_done = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg     <= in_data[2:0];
            sem_reg    <= in_data[5:3];
            ms_reg     <= in_data[25:6];
            before_reg <= cur_reg;
            newid_reg  <= '0;
            stat_reg   <= STAT_OK;
        end
        if (cmd.scan_step && op_reg == OP_TICK) begin
            if (sleft_reg[st] <= SleepW'(tick_ms_reg)) begin
                if (count_reg < CntW'(NumTasks)) begin
                    fifo_reg[tail_reg] <= st;
                end
            end else begin
                sleft_reg[st] <= sleft_reg[st] - SleepW'(tick_ms_reg);
                sord_reg[wr_reg[TidW-1:0]] <= st;
            end
        end
        if (cmd.exec && op_reg == OP_SPAWN && found) fifo_reg[tail_reg] <= rd_reg[TidW-1:0];
        if (cmd.exec && op_reg == OP_WAIT && semc_reg[sem_reg] == '0 && cur_reg != '0)
            link_reg[cur_reg] <= wtop_reg[sem_reg];
        if (cmd.exec && op_reg == OP_SIGNAL && wtop_reg[sem_reg] != '0)
            fifo_reg[tail_reg] <= wtop_reg[sem_reg];
        if (cmd.exec && op_reg == OP_SLEEP && cur_reg != '0) begin
            for (int i = 1; i < NumTasks; i++) sord_reg[i] <= sord_reg[i-1];
            sord_reg[0] <= cur_reg;
            sleft_reg[cur_reg] <= ms_reg;
        end
        if (cmd.slice && cur_reg != '0 && !(slice_reg[cur_reg] > 3'd1))
            fifo_reg[tail_reg] <= cur_reg;
        if (cmd.exec && op_reg == OP_SPAWN) begin
            if (found) newid_reg <= rd_reg[TidW-1:0];
            else       stat_reg  <= STAT_NO_ID;
        end
        if (cmd.exec && (op_reg == OP_WAIT && semc_reg[sem_reg] == '0 || op_reg == OP_SLEEP)
            && cur_reg == '0) stat_reg <= STAT_NOBLOCK;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slice_ticks_reg <= 3'd5;
            tick_ms_reg     <= 8'd10;
            used_reg        <= NumTasks'(1);
            head_reg        <= '0;
            tail_reg        <= '0;
            count_reg       <= '0;
            cur_reg         <= '0;
            slen_reg        <= '0;
            rd_reg          <= '0;
            wr_reg          <= '0;
            for (int i = 0; i < NumTasks; i++) slice_reg[i] <= 3'd5;
            for (int i = 0; i < NumSems; i++) begin
                semc_reg[i] <= '0;
                wtop_reg[i] <= '0;
            end
        end else begin
            if (cfg_we) begin
                if (cfg_idx == REG_SLICE) slice_ticks_reg <= cfg_data[SliceW-1:0];
                else                      tick_ms_reg     <= cfg_data;
            end
            if (cmd.scan_clr) begin
                rd_reg <= '0;
                wr_reg <= '0;
            end
            if (cmd.scan_step) begin
                rd_reg <= rd_reg + 1'b1;
                if (op_reg == OP_TICK) begin
                    if (sleft_reg[st] <= SleepW'(tick_ms_reg)) begin
                        if (count_reg < CntW'(NumTasks)) begin
                            tail_reg  <= tail_reg + 1'b1;
                            count_reg <= count_reg + 1'b1;
                        end
                    end else begin
                        wr_reg <= wr_reg + 1'b1;
                    end
                end
            end
            if (cmd.slice) begin
                slen_reg <= wr_reg;
                if (cur_reg != '0 && slice_reg[cur_reg] > 3'd1) begin
                    slice_reg[cur_reg] <= slice_reg[cur_reg] - 1'b1;
                end else begin
                    // requeue running task, if not idle, then pop head
                    if (cur_reg != '0) begin
                        slice_reg[cur_reg] <= slice_ticks_reg;
                        if (count_reg == '0) begin
                            // lone task: push and pop cancel
                            cur_reg <= cur_reg;
                        end else begin
                            cur_reg  <= fifo_reg[head_reg];
                            head_reg <= head_reg + 1'b1;
                            tail_reg <= tail_reg + 1'b1;
                        end
                    end else if (count_reg != '0) begin
                        cur_reg   <= fifo_reg[head_reg];
                        head_reg  <= head_reg + 1'b1;
                        count_reg <= count_reg - 1'b1;
                    end
                    if (cur_reg != '0 && count_reg == '0) begin
                        head_reg <= head_reg + 1'b1;
                        tail_reg <= tail_reg + 1'b1;
                    end
                end
            end
            if (cmd.exec) begin
                case (op_reg)
                    OP_SPAWN: if (found) begin
                        used_reg[rd_reg[TidW-1:0]]  <= 1'b1;
                        slice_reg[rd_reg[TidW-1:0]] <= slice_ticks_reg;
                        tail_reg  <= tail_reg + 1'b1;
                        count_reg <= count_reg + 1'b1;
                    end
                    OP_WAIT: if (semc_reg[sem_reg] != '0) begin
                        semc_reg[sem_reg] <= semc_reg[sem_reg] - 1'b1;
                    end else if (cur_reg != '0) begin
                        wtop_reg[sem_reg] <= cur_reg;
                        if (count_reg != '0) begin
                            cur_reg   <= fifo_reg[head_reg];
                            head_reg  <= head_reg + 1'b1;
                            count_reg <= count_reg - 1'b1;
                        end else begin
                            cur_reg <= '0;
                        end
                    end
                    OP_SIGNAL: if (wtop_reg[sem_reg] != '0) begin
                        wtop_reg[sem_reg] <= link_reg[wtop_reg[sem_reg]];
                        tail_reg  <= tail_reg + 1'b1;
                        count_reg <= count_reg + 1'b1;
                    end else if (semc_reg[sem_reg] != '1) begin
                        semc_reg[sem_reg] <= semc_reg[sem_reg] + 1'b1;
                    end
                    OP_SLEEP: if (cur_reg != '0) begin
                        slen_reg <= (slen_reg >= CntW'(NumTasks)) ? CntW'(NumTasks)
                                                                  : slen_reg + 1'b1;
                        if (count_reg != '0) begin
                            cur_reg   <= fifo_reg[head_reg];
                            head_reg  <= head_reg + 1'b1;
                            count_reg <= count_reg - 1'b1;
                        end else begin
                            cur_reg <= '0;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    assign res_load = cmd.emit;
    assign res_data = {1'b0, count_reg[TidW-1:0], stat_reg, newid_reg,
                       (cur_reg != before_reg), cur_reg};

endmodule

// ----- hdl/round_robin_task_scheduler.sv -----
// channel  | beat fields (low bit first)                                    | handshake
// s_       | opcode[2:0] sem_index[5:3] sleep_ms[25:6]                       | tvalid/tready
// m_       | running_task[3:0] switched[4] new_task[8:5] status[10:9] ready_len[14:11] | tvalid/tready
// cfg_     | 0 slice_ticks, 1 tick_ms                                       | cfg_we only
// an event walks the sleepers on a tick, or probes ids on a spawn, before it completes;
// the sleeper walk and id search set how long it takes
// synchronous active-low reset; idle task running, all queues empty
// one event in flight; s_tready drops until the result beat is loaded into the
// output register, which waits while an earlier result beat is still held there
module round_robin_task_scheduler (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // opcode, sem_index, sleep_ms
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // running_task, switched, new_task, status, ready_len
    input  logic        cfg_we,
    input  logic        cfg_idx,
    input  logic [7:0]  cfg_data
);
    import rrts_pkg::*;

    cmd_t cmd;
    sts_t sts;
    logic busy, res_load, in_fire, out_free;
    logic [OutW-1:0] res_data;
    logic [OutW-1:0] m_data_reg;
    logic m_valid_reg;

    assign s_tready = !busy;
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    rrts_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_fire(in_fire), .out_free(out_free),
        .sts(sts), .cmd(cmd), .busy(busy)
    );

    rrts_dp u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts), .in_data(s_tdata),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
        .res_data(res_data), .res_load(res_load)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) m_data_reg <= res_data;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // a new result never overwrites one still waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        res_load |-> (!m_valid_reg || m_tready))
        else $error("result overwritten");

    // no input accepted while an event is in flight
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> !s_tready)
        else $error("input accepted while busy");

    // status is always one of the three defined codes
    assert property (@(posedge aclk) disable iff (!aresetn)
        res_load |-> (res_data[10:9] != 2'd3))
        else $error("bad status code");

endmodule
